/* rtl/dmpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpg_pkg: shared types and constants for the moon phase glyph pipeline
// Field widths, calendar constants, the fixed-point reciprocal of the synodic
// month, the month term table and the illumination threshold table.
// ----------------------------------------------------------------------------
package dmpg_pkg;

	localparam int AGE_BITS = 24;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int JDN_W   = 22;
	localparam int IDX_W   = 5;
	localparam int GLYPH_W = 7;
	localparam int LIT_W   = 7;

	// calendar terms
	localparam int YADJ_W   = 14;
	localparam int TERM_M_W = 9;
	localparam int CENT_W   = 7;
	localparam int CENT_SHIFT = 19;
	localparam logic [MONTH_W-1:0] MARCH      = 4'd3;
	localparam logic [YADJ_W-1:0]  YEAR_OFS_A = 14'd4800;
	localparam logic [YADJ_W-1:0]  YEAR_OFS_C = 14'd4900;
	localparam logic [10:0]        DAYS_4Y    = 11'd1461;
	localparam logic [12:0]        CENT_RECIP = 13'd5243;
	localparam logic [JDN_W-1:0]   JDN_OFS    = 22'd32075;

	// moon age: t = 10*jdn - epoch in tenths of a day
	localparam int T_W = 24;
	localparam logic [JDN_W+3:0] EPOCH_TENTHS = 26'd24515501;
	localparam int RECIP_HALF  = 30;
	localparam int RECIP_FRAC  = 2 * RECIP_HALF;
	localparam int RECIP_INT_W = AGE_BITS - 8;
	localparam logic [127:0] RECIP_FULL =
		(128'd100000000 << (RECIP_FRAC + AGE_BITS)) / 128'd29530588853;
	localparam logic [RECIP_INT_W-1:0] RECIP_INT = RECIP_FULL[RECIP_FRAC +: RECIP_INT_W];
	localparam logic [RECIP_HALF-1:0]  RECIP_HI  = RECIP_FULL[RECIP_HALF +: RECIP_HALF];
	localparam logic [RECIP_HALF-1:0]  RECIP_LO  = RECIP_FULL[0 +: RECIP_HALF];
	localparam int PH_W  = T_W + RECIP_HALF + 1;
	localparam int PI_W  = T_W + RECIP_INT_W + 1;
	localparam int SUM_W = RECIP_HALF + AGE_BITS;
	localparam logic [AGE_BITS-1:0] AGE_HALF = AGE_BITS'(1) << (AGE_BITS - 1);

	// phase index and glyph codes
	localparam logic [IDX_W-1:0]   PHASES         = 5'd27;
	localparam logic [IDX_W-1:0]   PHASE_MIRROR   = 5'd28;
	localparam logic [IDX_W-1:0]   PHASE_FULL     = 5'd14;
	localparam logic [IDX_W-1:0]   PHASE_NEW      = 5'd0;
	localparam logic [GLYPH_W-1:0] GLYPH_FULL     = 7'd48;
	localparam logic [GLYPH_W-1:0] GLYPH_NEW      = 7'd49;
	localparam logic [GLYPH_W-1:0] GLYPH_WAX_OFS  = 7'd96;
	localparam logic [GLYPH_W-1:0] GLYPH_WANE_OFS = 7'd95;

	localparam int LIT_ENTRIES = 2 ** LIT_W;
	localparam int LIT_MAX     = 100;
	localparam real PI_RAD     = $acos(-1.0);

	typedef logic [2**MONTH_W-1:0][TERM_M_W-1:0] month_tbl_t;
	typedef logic [LIT_ENTRIES-1:0][AGE_BITS-1:0] lit_tbl_t;

	typedef struct packed {
		logic [JDN_W-1:0]      jdn;
		logic signed [T_W-1:0] t;
	} jdn_req_t;

	typedef struct packed {
		logic [JDN_W-1:0]    jdn;
		logic [AGE_BITS-1:0] age;
	} age_req_t;

	// 367 * (m - 2 - 12a) / 12 for every month code
	function automatic month_tbl_t build_month_tbl();
		month_tbl_t tbl;
		int i;
		int mm;
		for (i = 0; i < 2 ** MONTH_W; i++) begin
			mm = (i < 3) ? i + 10 : i - 2;
			tbl[i] = TERM_M_W'(367 * mm / 12);
		end
		return tbl;
	endfunction

	// smallest folded age reaching each whole percent of illumination
	function automatic lit_tbl_t build_lit_tbl();
		lit_tbl_t tbl;
		real x;
		longint c;
		int k;
		for (k = 0; k < LIT_ENTRIES; k++) begin
			if (k > LIT_MAX) begin
				tbl[k] = '1;
			end else begin
				x = $acos(1.0 - real'(k) / 50.0) / PI_RAD * (2.0 ** (AGE_BITS - 1));
				c = longint'(x);
				if (real'(c) < x) begin
					c = c + 1;
				end
				tbl[k] = AGE_BITS'(c);
			end
		end
		return tbl;
	endfunction

	localparam month_tbl_t MONTH_TERM = build_month_tbl();
	localparam lit_tbl_t   LIT_THR    = build_lit_tbl();

endpackage

/* rtl/dmpg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpg_if: request channels of the moon phase glyph block
// Date requests in, phase results out, each with valid and ready.
// ----------------------------------------------------------------------------
interface dmpg_date_if;
	import dmpg_pkg::*;

	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day;

	modport source (output valid, year, month, day, input ready);
	modport sink   (input valid, year, month, day, output ready);
endinterface

interface dmpg_phase_if;
	import dmpg_pkg::*;

	logic                valid;
	logic                ready;
	logic [JDN_W-1:0]    julian_day;
	logic [AGE_BITS-1:0] age_fraction;
	logic [IDX_W-1:0]    phase_index;
	logic [GLYPH_W-1:0]  glyph_code;
	logic [LIT_W-1:0]    lit_percent;
	logic                waning;

	modport source (output valid, julian_day, age_fraction, phase_index, glyph_code,
		lit_percent, waning, input ready);
	modport sink   (input valid, julian_day, age_fraction, phase_index, glyph_code,
		lit_percent, waning, output ready);
endinterface

/* rtl/dmpg_jdn.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpg_jdn: Julian day number stages
// Three stages: calendar terms, day number sum, day offset from the epoch
// in tenths of a day.
// ----------------------------------------------------------------------------
module dmpg_jdn (
	input  logic               clk,
	input  logic               arst_n,
	dmpg_date_if.sink          date,
	output logic               out_valid,
	input  logic               out_ready,
	output dmpg_pkg::jdn_req_t out_req
);
	import dmpg_pkg::*;

	logic adv1, adv2, adv3;
	logic valid_s1, valid_s2, valid_s3;

	logic                     early;
	logic [YADJ_W-1:0]        ya, yc;
	logic [YADJ_W+10:0]       prod_a;
	logic [YADJ_W+12:0]       prod_c;
	logic [CENT_W-1:0]        cent;
	logic [CENT_W+1:0]        cent3;
	logic [JDN_W+3:0]         tenths;

	logic [JDN_W-1:0]         term_a_s1;
	logic [CENT_W-1:0]        term_c_s1;
	logic [TERM_M_W-1:0]      term_m_s1;
	logic [DAY_W-1:0]         day_s1;
	logic [JDN_W-1:0]         jdn_s2;
	logic [JDN_W-1:0]         jdn_s3;
	logic signed [T_W-1:0]    t_s3;

	assign adv3 = !valid_s3 || out_ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign date.ready = adv1;

	always_comb begin
		early  = date.month < MARCH;
		ya     = YADJ_W'(date.year) + YEAR_OFS_A - YADJ_W'(early);
		yc     = YADJ_W'(date.year) + YEAR_OFS_C - YADJ_W'(early);
		prod_a = (YADJ_W + 11)'(ya) * (YADJ_W + 11)'(DAYS_4Y);
		prod_c = (YADJ_W + 13)'(yc) * (YADJ_W + 13)'(CENT_RECIP);
		cent   = prod_c[CENT_SHIFT +: CENT_W];
		cent3  = (CENT_W + 2)'({cent, 1'b0}) + (CENT_W + 2)'(cent);
		tenths = (JDN_W + 4)'({jdn_s2, 3'b000}) + (JDN_W + 4)'({jdn_s2, 1'b0})
			- EPOCH_TENTHS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= date.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && date.valid) begin
			term_a_s1 <= prod_a[JDN_W+1:2];
			term_c_s1 <= cent3[CENT_W+1:2];
			term_m_s1 <= MONTH_TERM[date.month];
			day_s1    <= date.day;
		end
		if (adv2 && valid_s1) begin
			jdn_s2 <= JDN_W'(day_s1) + term_a_s1 + JDN_W'(term_m_s1)
				- JDN_W'(term_c_s1) - JDN_OFS;
		end
		if (adv3 && valid_s2) begin
			jdn_s3 <= jdn_s2;
			t_s3   <= $signed(tenths[T_W-1:0]);
		end
	end

	assign out_valid   = valid_s3;
	assign out_req.jdn = jdn_s3;
	assign out_req.t   = t_s3;

endmodule

/* rtl/dmpg_age.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpg_age: moon age stages
// Multiplies the epoch offset by the reciprocal of the synodic month in
// three partial products, merges them and keeps the fraction bits.
// ----------------------------------------------------------------------------
module dmpg_age (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dmpg_pkg::jdn_req_t in_req,
	output logic               out_valid,
	input  logic               out_ready,
	output dmpg_pkg::age_req_t out_req
);
	import dmpg_pkg::*;

	logic adv4, adv5, adv6;
	logic valid_s4, valid_s5, valid_s6;

	logic signed [PI_W-1:0] prod_int;
	logic signed [PH_W-1:0] prod_hi, prod_lo;

	logic [JDN_W-1:0]       jdn_s4, jdn_s5, jdn_s6;
	logic [AGE_BITS-1:0]    int_s4, int_s5;
	logic signed [PH_W-1:0] hi_s4, lo_s4;
	logic [SUM_W-1:0]       sum_s5;
	logic [AGE_BITS-1:0]    age_s6;

	assign adv6 = !valid_s6 || out_ready;
	assign adv5 = !valid_s5 || adv6;
	assign adv4 = !valid_s4 || adv5;
	assign in_ready = adv4;

	always_comb begin
		prod_int = PI_W'(in_req.t) * PI_W'($signed({1'b0, RECIP_INT}));
		prod_hi  = PH_W'(in_req.t) * PH_W'($signed({1'b0, RECIP_HI}));
		prod_lo  = PH_W'(in_req.t) * PH_W'($signed({1'b0, RECIP_LO}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv4) begin
				valid_s4 <= in_valid;
			end
			if (adv5) begin
				valid_s5 <= valid_s4;
			end
			if (adv6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && in_valid) begin
			jdn_s4 <= in_req.jdn;
			int_s4 <= prod_int[AGE_BITS-1:0];
			hi_s4  <= prod_hi;
			lo_s4  <= prod_lo;
		end
		if (adv5 && valid_s4) begin
			jdn_s5 <= jdn_s4;
			int_s5 <= int_s4;
			sum_s5 <= SUM_W'(hi_s4) + SUM_W'(lo_s4 >>> RECIP_HALF);
		end
		if (adv6 && valid_s5) begin
			jdn_s6 <= jdn_s5;
			age_s6 <= sum_s5[RECIP_HALF +: AGE_BITS] + int_s5;
		end
	end

	assign out_valid   = valid_s6;
	assign out_req.jdn = jdn_s6;
	assign out_req.age = age_s6;

endmodule

/* rtl/dmpg_phase.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpg_phase: phase index, glyph and illumination stages
// Rounds the age to a phase index, mirrors it for the southern hemisphere,
// picks the glyph and finds the illuminated percentage by a binary search
// of the threshold table spread over three stages.
// ----------------------------------------------------------------------------
module dmpg_phase (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dmpg_pkg::age_req_t in_req,
	input  logic               south,
	dmpg_phase_if.source       phase
);
	import dmpg_pkg::*;

	logic adv7, adv8, adv9, adv10;
	logic valid_s7, valid_s8, valid_s9, valid_s10;

	logic [AGE_BITS+IDX_W-1:0] prod27;
	logic [IDX_W-1:0]          idx_c;
	logic [GLYPH_W-1:0]        glyph_c;

	logic [JDN_W-1:0]    jdn_s7, jdn_s8, jdn_s9, jdn_s10;
	logic [AGE_BITS-1:0] age_s7, age_s8, age_s9, age_s10;
	logic [AGE_BITS-1:0] fold_s7, fold_s8, fold_s9;
	logic [IDX_W-1:0]    idx_s7, idx_s8, idx_s9, idx_s10;
	logic [GLYPH_W-1:0]  glyph_s8, glyph_s9, glyph_s10;
	logic [LIT_W-1:0]    lit_s8, lit_s9, lit_s10;
	logic                waning_s7, waning_s8, waning_s9, waning_s10;

	function automatic logic [LIT_W-1:0] lit_refine(
		input logic [AGE_BITS-1:0] fold,
		input logic [LIT_W-1:0]    lit_in,
		input int                  hi,
		input int                  lo
	);
		logic [LIT_W-1:0] lit;
		logic [LIT_W-1:0] cand;
		lit = lit_in;
		for (int b = hi; b >= lo; b--) begin
			cand = lit | (LIT_W'(1) << b);
			if (fold >= LIT_THR[cand]) begin
				lit = cand;
			end
		end
		return lit;
	endfunction

	assign adv10 = !valid_s10 || phase.ready;
	assign adv9  = !valid_s9 || adv10;
	assign adv8  = !valid_s8 || adv9;
	assign adv7  = !valid_s7 || adv8;
	assign in_ready = adv7;

	always_comb begin
		prod27 = (AGE_BITS + IDX_W)'(in_req.age) * (AGE_BITS + IDX_W)'(PHASES)
			+ (AGE_BITS + IDX_W)'(AGE_HALF);
		idx_c = (south && idx_s7 != PHASE_NEW) ? PHASE_MIRROR - idx_s7 : idx_s7;
		priority if (idx_c == PHASE_FULL) begin
			glyph_c = GLYPH_FULL;
		end else if (idx_c == PHASE_NEW) begin
			glyph_c = GLYPH_NEW;
		end else if (idx_c < PHASE_FULL) begin
			glyph_c = GLYPH_W'(idx_c) + GLYPH_WAX_OFS;
		end else begin
			glyph_c = GLYPH_W'(idx_c) + GLYPH_WANE_OFS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			if (adv7) begin
				valid_s7 <= in_valid;
			end
			if (adv8) begin
				valid_s8 <= valid_s7;
			end
			if (adv9) begin
				valid_s9 <= valid_s8;
			end
			if (adv10) begin
				valid_s10 <= valid_s9;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv7 && in_valid) begin
			jdn_s7    <= in_req.jdn;
			age_s7    <= in_req.age;
			idx_s7    <= prod27[AGE_BITS +: IDX_W];
			fold_s7   <= in_req.age[AGE_BITS-1] ? AGE_BITS'(0) - in_req.age : in_req.age;
			waning_s7 <= in_req.age[AGE_BITS-1];
		end
		if (adv8 && valid_s7) begin
			jdn_s8    <= jdn_s7;
			age_s8    <= age_s7;
			fold_s8   <= fold_s7;
			idx_s8    <= idx_c;
			glyph_s8  <= glyph_c;
			lit_s8    <= lit_refine(fold_s7, '0, LIT_W - 1, LIT_W - 3);
			waning_s8 <= waning_s7;
		end
		if (adv9 && valid_s8) begin
			jdn_s9    <= jdn_s8;
			age_s9    <= age_s8;
			fold_s9   <= fold_s8;
			idx_s9    <= idx_s8;
			glyph_s9  <= glyph_s8;
			lit_s9    <= lit_refine(fold_s8, lit_s8, LIT_W - 4, LIT_W - 5);
			waning_s9 <= waning_s8;
		end
		if (adv10 && valid_s9) begin
			jdn_s10    <= jdn_s9;
			age_s10    <= age_s9;
			idx_s10    <= idx_s9;
			glyph_s10  <= glyph_s9;
			lit_s10    <= lit_refine(fold_s9, lit_s9, LIT_W - 6, 0);
			waning_s10 <= waning_s9;
		end
	end

	assign phase.valid        = valid_s10;
	assign phase.julian_day   = jdn_s10;
	assign phase.age_fraction = age_s10;
	assign phase.phase_index  = idx_s10;
	assign phase.glyph_code   = glyph_s10;
	assign phase.lit_percent  = lit_s10;
	assign phase.waning       = waning_s10;

endmodule

/* rtl/date_to_moon_phase_glyph.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_to_moon_phase_glyph: Gregorian date to moon phase glyph
// Julian day number, moon age fraction, phase index, font glyph,
// illuminated percentage and waning flag for one date per request.
//
//  channel   dir  handshake            payload
//  date      in   valid / ready        year, month, day
//  phase     out  valid / ready        julian_day, age_fraction, phase_index,
//                                      glyph_code, lit_percent, waning
//  cfg       in   cfg_wr_en            cfg_wr_data (southern hemisphere)
//
// One request per cycle while the output is not stalled; each result passes
// through every register stage of the ten-stage pipeline in order.
// Each stage advances when it is empty or the next one advances, so bubbles
// close up and a stalled output holds every stage in place.
// Reset clears the stage valid bits and the hemisphere register.
// ----------------------------------------------------------------------------
module date_to_moon_phase_glyph (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,
	dmpg_date_if.sink    date,
	dmpg_phase_if.source phase
);
	import dmpg_pkg::*;

	logic     southern_q;
	logic     jdn_valid, jdn_ready;
	jdn_req_t jdn_req;
	logic     age_valid, age_ready;
	age_req_t age_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			southern_q <= 1'b0;
		end else if (cfg_wr_en) begin
			southern_q <= cfg_wr_data;
		end
	end

	dmpg_jdn u_jdn (
		.clk       (clk),
		.arst_n    (arst_n),
		.date      (date),
		.out_valid (jdn_valid),
		.out_ready (jdn_ready),
		.out_req   (jdn_req)
	);

	dmpg_age u_age (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (jdn_valid),
		.in_ready  (jdn_ready),
		.in_req    (jdn_req),
		.out_valid (age_valid),
		.out_ready (age_ready),
		.out_req   (age_req)
	);

	dmpg_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (age_valid),
		.in_ready (age_ready),
		.in_req   (age_req),
		.south    (southern_q),
		.phase    (phase)
	);

endmodule

/* dv/tb_date_to_moon_phase_glyph.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_to_moon_phase_glyph: moon phase glyph block testbench
// Drives date requests from a queue and checks every phase result against a
// behavioral predictor that handles Julian day, moon age, phase index, glyph,
// illumination and waning. Both channels idle in random bursts. The receiver
// holds off long enough once to back the pipeline up into its input. The
// hemisphere register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_date_to_moon_phase_glyph;
	import dmpg_pkg::*;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		logic [JDN_W-1:0]    jdn;
		logic [AGE_BITS-1:0] age;
		logic [IDX_W-1:0]    idx;
		logic [GLYPH_W-1:0]  glyph;
		logic [LIT_W-1:0]    lit;
		logic                waning;
	} phase_t;

	localparam longint SYNODIC_NDAYS = 64'sd29530588853;
	localparam longint EPOCH_TENTH_DAYS = 64'sd24515501;
	localparam int LONG_HOLD_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	logic  d_valid = 1'b0;
	date_t d_req = '0;
	logic  p_ready = 1'b0;
	logic  date_taken = 1'b0;

	date_t  pending_dates[$];
	phase_t phase_expected[$];
	phase_t want;
	logic   south_shadow = 1'b0;
	int     errors = 0;
	int     idle_pct = 0;
	int     send_gap = 0;
	int     recv_gap = 0;
	int     long_hold = 0;
	logic   squeeze = 1'b0;
	logic   squeezed = 1'b0;

	dmpg_date_if  date_ch();
	dmpg_phase_if phase_ch();

	assign date_ch.valid  = d_valid;
	assign date_ch.year   = d_req.year;
	assign date_ch.month  = d_req.month;
	assign date_ch.day    = d_req.day;
	assign phase_ch.ready = p_ready;

	date_to_moon_phase_glyph i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.date        (date_ch),
		.phase       (phase_ch)
	);

	always #2 clk = ~clk;

	function automatic phase_t moon_phase_of(date_t d, logic south);
		longint y;
		longint m;
		longint dd;
		longint a;
		longint jdn;
		longint rem;
		longint age;
		longint idx;
		longint glyph;
		longint f;
		longint lit;
		longint half;
		longint quarter;
		real    s;
		phase_t r;
		y = d.year;
		m = d.month;
		dd = d.day;
		a = (m <= 2) ? -1 : 0;
		jdn = dd - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - 12 * a) / 12
			- 3 * ((y + 4900 + a) / 100) / 4;
		rem = ((10 * jdn - EPOCH_TENTH_DAYS) * 100000000) % SYNODIC_NDAYS;
		if (rem < 0)
			rem = rem + SYNODIC_NDAYS;
		age = (rem << AGE_BITS) / SYNODIC_NDAYS;
		half = 64'sd1 << (AGE_BITS - 1);
		quarter = 64'sd1 << (AGE_BITS - 2);
		idx = (age * 27 + half) >> AGE_BITS;
		if (south && idx > 0)
			idx = longint'(PHASE_MIRROR) - idx;
		if (idx == longint'(PHASE_FULL))
			glyph = GLYPH_FULL;
		else if (idx == longint'(PHASE_NEW))
			glyph = GLYPH_NEW;
		else if (idx < longint'(PHASE_FULL))
			glyph = idx + longint'(GLYPH_WAX_OFS);
		else
			glyph = idx + longint'(GLYPH_WANE_OFS);
		// fold onto the waxing half; 50*(1-cos(2 pi x)) = 100*sin^2(pi x)
		f = (age <= half) ? age : (64'sd1 << AGE_BITS) - age;
		if (f == quarter) begin
			lit = 50;
		end else if (f == half) begin
			lit = 100;
		end else begin
			s = $sin(3.14159265358979323846 * real'(f) / (2.0 ** AGE_BITS));
			lit = longint'($floor(100.0 * s * s));
		end
		r.jdn = JDN_W'(jdn);
		r.age = AGE_BITS'(age);
		r.idx = IDX_W'(idx);
		r.glyph = GLYPH_W'(glyph);
		r.lit = LIT_W'(lit);
		r.waning = (age >= half);
		return r;
	endfunction

	function automatic date_t random_date();
		date_t d;
		if ($urandom_range(0, 9) == 0) begin
			d.year = YEAR_W'($urandom);
			d.month = MONTH_W'($urandom);
			d.day = DAY_W'($urandom);
		end else begin
			d.year = YEAR_W'($urandom_range(1583, 4095));
			d.month = MONTH_W'($urandom_range(1, 12));
			d.day = DAY_W'($urandom_range(1, 31));
		end
		return d;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $realtime, name,
				exp_val, got_val);
			errors++;
		end
	endtask

	task automatic drain();
		while (pending_dates.size() != 0 || d_valid || phase_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_hemisphere(logic south);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= south;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!d_valid || date_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				d_valid <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				send_gap <= $urandom_range(0, 6);
				d_valid <= 1'b0;
			end else if (pending_dates.size() != 0) begin
				d_req <= pending_dates.pop_front();
				d_valid <= 1'b1;
			end else begin
				d_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (squeeze && !squeezed) begin
			squeezed <= 1'b1;
			long_hold <= LONG_HOLD_CYCLES;
			p_ready <= 1'b0;
		end else if (long_hold > 0) begin
			long_hold <= long_hold - 1;
			p_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			p_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			recv_gap <= $urandom_range(0, 6);
			p_ready <= 1'b0;
		end else begin
			p_ready <= 1'b1;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		date_taken <= arst_n && d_valid && date_ch.ready;
		if (arst_n) begin
			if (cfg_wr_en)
				south_shadow <= cfg_wr_data;
			if (phase_ch.valid && p_ready) begin
				if (phase_expected.size() == 0) begin
					$display("%0t unexpected result: julian_day %0d", $realtime,
						phase_ch.julian_day);
					errors++;
				end else begin
					want = phase_expected.pop_front();
					check_field("julian_day", want.jdn, phase_ch.julian_day);
					check_field("age_fraction", want.age, phase_ch.age_fraction);
					check_field("phase_index", want.idx, phase_ch.phase_index);
					check_field("glyph_code", want.glyph, phase_ch.glyph_code);
					check_field("lit_percent", want.lit, phase_ch.lit_percent);
					check_field("waning", want.waning, phase_ch.waning);
				end
			end
			if (d_valid && date_ch.ready)
				phase_expected.push_back(moon_phase_of(d_req, south_shadow));
		end
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_hemisphere(1'b0);
		idle_pct = 20;
		pending_dates.push_back({12'd0, 4'd0, 5'd0});
		pending_dates.push_back({12'd4095, 4'd15, 5'd31});
		pending_dates.push_back({12'd1583, 4'd1, 5'd1});
		pending_dates.push_back({12'd1582, 4'd10, 5'd15});
		pending_dates.push_back({12'd2000, 4'd1, 5'd6});
		pending_dates.push_back({12'd2000, 4'd1, 5'd7});
		pending_dates.push_back({12'd1999, 4'd12, 5'd31});
		pending_dates.push_back({12'd2024, 4'd2, 5'd29});
		pending_dates.push_back({12'd2023, 4'd2, 5'd31});
		pending_dates.push_back({12'd2024, 4'd3, 5'd0});
		pending_dates.push_back({12'd2024, 4'd13, 5'd5});
		pending_dates.push_back({12'd2024, 4'd14, 5'd31});
		pending_dates.push_back({12'd2024, 4'd15, 5'd1});
		pending_dates.push_back({12'd4095, 4'd12, 5'd31});
		pending_dates.push_back({12'd4095, 4'd1, 5'd1});
		pending_dates.push_back({12'd0, 4'd12, 5'd31});
		pending_dates.push_back({12'd2047, 4'd7, 5'd21});
		pending_dates.push_back({12'd2048, 4'd8, 5'd10});
		pending_dates.push_back({12'd1024, 4'd5, 5'd16});
		pending_dates.push_back({12'd3000, 4'd6, 5'd15});
		pending_dates.push_back({12'd1900, 4'd2, 5'd28});
		pending_dates.push_back({12'd2100, 4'd3, 5'd1});
		drain();

		write_hemisphere(1'b1);
		idle_pct = 25;
		repeat (300) pending_dates.push_back(random_date());
		squeeze = 1'b1;
		drain();

		write_hemisphere(1'b0);
		idle_pct = 40;
		repeat (300) pending_dates.push_back(random_date());
		drain();

		write_hemisphere(1'b1);
		idle_pct = 0;
		repeat (280) pending_dates.push_back(random_date());
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0 && phase_expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
